// File: design/cbyp_pkg.sv
// shared types, constants and the cordic arctangent table for the camera basis unit
`default_nettype none
package cbyp_pkg;

  localparam int IN_W         = 17;
  localparam int OUT_W        = 16;
  localparam int CW           = 32;
  localparam int ZW           = 26;
  localparam int IFB          = 28;
  localparam int CORDIC_STEPS = 23;
  localparam int LEN_W        = 32;
  localparam int SQ_W         = 64;
  localparam int ROOT_STEPS   = 32;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][OUT_W-1:0] ovec_t;

  localparam comp_t CORDIC_K = 32'sd163008219;
  localparam ang_t DEG90  = 26'sd5898240;
  localparam ang_t DEG180 = 26'sd11796480;
  localparam ang_t DEG360 = 26'sd23592960;
  localparam logic [CW-1:0] DEGEN_LIMIT = 32'd8192;

  // arctangent of 2^-i in degrees, 16 fraction bits
  function automatic ang_t atan_deg16(input int i);
    ang_t a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: design/cbyp_angle.sv
// three stage angle reduction: modulo 360 degrees, fold into -90..+90 with half-turn flag
`default_nettype none
module cbyp_angle import cbyp_pkg::*; #(
  parameter int AFB = 7
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] ang,
  output ang_t                   r,
  output logic                   neg
);

  localparam int MOD  = 360 << AFB;
  localparam int BIAS = (((1 << (IN_W - 1)) + MOD - 1) / MOD) * MOD;
  localparam int VW   = $clog2((1 << IN_W) + MOD) + 1;
  localparam longint RECIP = (longint'(1) << 32) / longint'(MOD);
  localparam int RW   = $clog2(RECIP + 1);
  localparam int PW   = VW + RW;
  localparam int QW   = PW - 32;
  localparam int SH   = 16 - AFB;

  logic signed [VW-1:0] vs;
  logic [VW-1:0] vu;
  logic [VW-1:0] v1;
  logic [PW-1:0] p1;
  logic [QW-1:0] q;
  logic [VW-1:0] qm;
  logic [VW-1:0] rm;
  logic [VW-1:0] rc;
  logic [VW-1:0] rem2;
  ang_t d;
  ang_t w;
  ang_t f;
  logic fneg;

  // bias to a non-negative value that is a whole number of turns away
  assign vs = VW'(ang) + VW'(BIAS);
  assign vu = vs;

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= vu;
      p1 <= PW'(vu) * PW'(RECIP);
    end
  end

  // reciprocal quotient is low by at most one
  assign q  = p1[PW-1:32];
  assign qm = VW'(q * MOD);
  assign rm = v1 - qm;
  assign rc = (rm >= VW'(MOD)) ? rm - VW'(MOD) : rm;

  always_ff @(posedge clk) begin
    if (en) begin
      rem2 <= rc;
    end
  end

  always_comb begin
    d    = ang_t'(ZW'(rem2) << SH);
    w    = (d > DEG180) ? d - DEG360 : d;
    f    = w;
    fneg = 1'b0;
    if (w > DEG90) begin
      f    = w - DEG180;
      fneg = 1'b1;
    end else if (w < -DEG90) begin
      f    = w + DEG180;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= f;
      neg <= fneg;
    end
  end

endmodule
`default_nettype wire

// File: design/cbyp_cordic.sv
// pipelined rotation-mode cordic, one stage per step, sign fix in a last stage
`default_nettype none
module cbyp_cordic import cbyp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ang_t  r,
  input  logic  neg,
  output comp_t c,
  output comp_t s
);

  comp_t xs [1:CORDIC_STEPS];
  comp_t ys [1:CORDIC_STEPS];
  ang_t  zs [1:CORDIC_STEPS-1];
  logic  ng [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    comp_t xi;
    comp_t yi;
    ang_t  zi;
    logic  gi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_K;
      assign yi = '0;
      assign zi = r;
      assign gi = neg;
    end else begin : g_rest
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
      assign gi = ng[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= gi;
        if (zi >= 0) begin
          xs[i+1] <= xi - (yi >>> i);
          ys[i+1] <= yi + (xi >>> i);
        end else begin
          xs[i+1] <= xi + (yi >>> i);
          ys[i+1] <= yi - (xi >>> i);
        end
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          zs[i+1] <= (zi >= 0) ? zi - atan_deg16(i) : zi + atan_deg16(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c <= ng[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
      s <= ng[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire

// File: design/cbyp_norm.sv
// pipelined 3-vector normalizer: squares, sum, digit-per-stage square root, restoring divide
`default_nettype none
module cbyp_norm import cbyp_pkg::*; #(
  parameter int VFB = 15
) (
  input  logic  clk,
  input  logic  en,
  input  vec_t  vin,
  output ovec_t vout
);

  localparam int QW = VFB + 1;
  localparam int DW = LEN_W + VFB + 1;
  localparam logic [QW-1:0] LIM = QW'((1 << VFB) - 1);

  logic [2:0][CW-1:0] a0;
  logic [2:0][CW-1:0] a1;
  logic [2:0]         n1;
  logic [2:0][SQ_W-1:0] sq1;
  logic [2:0][CW-1:0] a2;
  logic [2:0]         n2;
  logic [SQ_W-1:0]    sum2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a0[k] = vin[k][CW-1] ? (~vin[k] + CW'(1)) : vin[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a1[k]  <= a0[k];
        n1[k]  <= vin[k][CW-1];
        sq1[k] <= SQ_W'(a0[k]) * SQ_W'(a0[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2 <= sq1[0] + sq1[1] + sq1[2];
      a2   <= a1;
      n2   <= n1;
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]    rn [1:ROOT_STEPS-1];
  logic [SQ_W-1:0]    rr [1:ROOT_STEPS];
  logic [2:0][CW-1:0] ra [1:ROOT_STEPS];
  logic [2:0]         rg [1:ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SQ_W-1:0] BITC = SQ_W'(1) << (62 - 2 * k);
    logic [SQ_W-1:0]    ni;
    logic [SQ_W-1:0]    ri;
    logic [2:0][CW-1:0] ai;
    logic [2:0]         gi;
    logic [SQ_W-1:0]    trial;
    logic               ge;
    if (k == 0) begin : g_first
      assign ni = sum2;
      assign ri = '0;
      assign ai = a2;
      assign gi = n2;
    end else begin : g_rest
      assign ni = rn[k];
      assign ri = rr[k];
      assign ai = ra[k];
      assign gi = rg[k];
    end
    assign trial = ri + BITC;
    assign ge    = (ni >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k+1] <= ge ? (ri >> 1) + BITC : (ri >> 1);
        ra[k+1] <= ai;
        rg[k+1] <= gi;
      end
    end

    if (k < ROOT_STEPS - 1) begin : g_n
      always_ff @(posedge clk) begin
        if (en) begin
          rn[k+1] <= ge ? ni - trial : ni;
        end
      end
    end
  end

  // rounded divide by the length, one quotient bit per stage
  logic [2:0][DW-1:0] dr [1:QW-1];
  logic [2:0][QW-1:0] dq [1:QW];
  logic [LEN_W-1:0]   dl [1:QW];
  logic [2:0]         dg [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LEN_W-1:0]   li;
    logic [2:0][DW-1:0] remi;
    logic [2:0][QW-1:0] qi;
    logic [2:0]         gi;
    logic [DW-1:0]      dd;
    logic [2:0][DW-1:0] remo;
    logic [2:0][QW-1:0] qo;
    if (j == 0) begin : g_first
      assign li = rr[ROOT_STEPS][LEN_W-1:0];
      assign gi = rg[ROOT_STEPS];
      assign qi = '0;
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          remi[k] = (DW'(ra[ROOT_STEPS][k]) << VFB) + DW'(li >> 1);
        end
      end
    end else begin : g_rest
      assign li   = dl[j];
      assign gi   = dg[j];
      assign qi   = dq[j];
      assign remi = dr[j];
    end
    assign dd = DW'(li) << (VFB - j);

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        remo[k] = (remi[k] >= dd) ? remi[k] - dd : remi[k];
        qo[k]   = (qi[k] << 1) | QW'(remi[k] >= dd);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[j+1] <= qo;
        dl[j+1] <= li;
        dg[j+1] <= gi;
      end
    end

    if (j < QW - 1) begin : g_r
      always_ff @(posedge clk) begin
        if (en) begin
          dr[j+1] <= remo;
        end
      end
    end
  end

  // saturate, restore sign, zero length gives zero
  logic [2:0][QW-1:0] qs;
  logic signed [QW:0] sv [0:2];
  ovec_t              vo;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = (dq[QW][k] > LIM) ? LIM : dq[QW][k];
      sv[k] = dg[QW][k] ? -$signed({1'b0, qs[k]}) : $signed({1'b0, qs[k]});
      vo[k] = (dl[QW] == '0) ? '0 : OUT_W'(sv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout <= vo;
    end
  end

endmodule
`default_nettype wire

// File: design/camera_basis_from_yaw_pitch_unit.sv
// camera front, right and up unit vectors from pitch and yaw angles
// throughput: one request per cycle while the output is not stalled; the angle fold, the 23 cordic steps, the 32 square
// root steps and the divider bits each own a register stage
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset clears only the valid pipeline; data registers are not reset
`default_nettype none
module camera_basis_from_yaw_pitch_unit import cbyp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = 7,
  parameter int VECTOR_FRAC_BITS = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // pitch_deg, yaw_deg
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // front_x/y/z, right_x/y/z, up_x/y/z
  output logic         m_tuser    // degenerate
);

  localparam int LN  = 36 + VECTOR_FRAC_BITS;
  localparam int LAT = 3 + (CORDIC_STEPS + 1) + 2 + LN + 1;

  logic en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  ang_t rp, ry;
  logic np, ny;
  comp_t cp, sp, cy, sy;

  cbyp_angle #(.AFB(ANGLE_FRAC_BITS)) u_ang_p (
    .clk(clk), .en(en), .ang($signed(s_tdata[16:0])), .r(rp), .neg(np)
  );
  cbyp_angle #(.AFB(ANGLE_FRAC_BITS)) u_ang_y (
    .clk(clk), .en(en), .ang($signed(s_tdata[33:17])), .r(ry), .neg(ny)
  );

  cbyp_cordic u_cor_p (.clk(clk), .en(en), .r(rp), .neg(np), .c(cp), .s(sp));
  cbyp_cordic u_cor_y (.clk(clk), .en(en), .r(ry), .neg(ny), .c(cy), .s(sy));

  // products of sines and cosines
  logic signed [2*CW-1:0] m_cycp, m_sycp, m_cysp, m_sysp;
  comp_t cyp1, syp1, cys1, sys1, cp1, sp1, cy1, sy1;

  assign m_cycp = cy * cp;
  assign m_sycp = sy * cp;
  assign m_cysp = cy * sp;
  assign m_sysp = sy * sp;

  always_ff @(posedge clk) begin
    if (en) begin
      cyp1 <= CW'(m_cycp >>> IFB);
      syp1 <= CW'(m_sycp >>> IFB);
      cys1 <= CW'(m_cysp >>> IFB);
      sys1 <= CW'(m_sysp >>> IFB);
      cp1  <= cp;
      sp1  <= sp;
      cy1  <= cy;
      sy1  <= sy;
    end
  end

  // direction vectors, right and up carry the sign of cos(pitch)
  vec_t fv2, rv2, uv2;
  logic degen2;
  logic cneg;
  comp_t cabs;

  assign cneg = cp1 < 0;
  assign cabs = cneg ? -cp1 : cp1;

  always_ff @(posedge clk) begin
    if (en) begin
      degen2 <= cabs < $signed(DEGEN_LIMIT);
      fv2[0] <= cyp1;
      fv2[1] <= sp1;
      fv2[2] <= syp1;
      rv2[0] <= cneg ? sy1 : -sy1;
      rv2[1] <= '0;
      rv2[2] <= cneg ? -cy1 : cy1;
      uv2[0] <= cneg ? cys1 : -cys1;
      uv2[1] <= cneg ? -cp1 : cp1;
      uv2[2] <= cneg ? sys1 : -sys1;
    end
  end

  ovec_t fo, ro, uo;

  cbyp_norm #(.VFB(VECTOR_FRAC_BITS)) u_norm_f (.clk(clk), .en(en), .vin(fv2), .vout(fo));
  cbyp_norm #(.VFB(VECTOR_FRAC_BITS)) u_norm_r (.clk(clk), .en(en), .vin(rv2), .vout(ro));
  cbyp_norm #(.VFB(VECTOR_FRAC_BITS)) u_norm_u (.clk(clk), .en(en), .vin(uv2), .vout(uo));

  logic [LN-1:0] dg_d;

  always_ff @(posedge clk) begin
    if (en) begin
      dg_d <= {dg_d[LN-2:0], degen2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {(dg_d[LN-1] ? ovec_t'('0) : uo), (dg_d[LN-1] ? ovec_t'('0) : ro), fo};
      m_tuser <= dg_d[LN-1];
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[143:48] == '0)
    else $error("degenerate result carries nonzero right or up");

  a_right_y_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[79:64] == '0)
    else $error("right_y is not zero");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for the camera basis unit: directed table then random angle pairs
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cbyp_pkg::*;

  localparam int AFB = 7;
  localparam int VFB = 15;
  localparam int LATENCY = 66 + VFB;
  localparam int WATCHDOG = 20000;
  localparam longint D90 = 5898240;
  localparam longint D180 = 11796480;
  localparam longint D360 = 23592960;
  localparam longint DEGEN_LIM = 8192;
  localparam longint GAIN = 163008219;
  localparam int NUM_RANDOM = 1800;

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    logic degen;
  } basis_t;

  typedef struct {
    logic signed [16:0] pitch;
    logic signed [16:0] yaw;
    bit known;
    basis_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic m_tuser;

  basis_t basis_q[$];
  int fails = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  camera_basis_from_yaw_pitch_unit #(.ANGLE_FRAC_BITS(AFB), .VECTOR_FRAC_BITS(VFB)) u_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return tbl[i];
  endfunction

  function automatic void rotate_angle(input longint deg16, output longint c,
                                       output longint s);
    longint r, x, y, dx, dy;
    bit flip;
    r = deg16 % D360;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (r < 0) r += D360;
    if (r > D180) r -= D360;
    if (r > D90) begin
      r -= D180;
      flip = 1'b1;
    end else if (r < -D90) begin
      r += D180;
      flip = 1'b1;
    end
    for (int i = 0; i < 23; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (r >= 0) begin
        x -= dx;
        y += dy;
        r -= arctan_step(i);
      end else begin
        x += dx;
        y -= dy;
        r += arctan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v[3], output logic signed [15:0] o[3]);
    longint unsigned sum, len, m, q, lim;
    sum = 0;
    lim = (64'd1 << VFB) - 1;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      sum += m * m;
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        o[k] = '0;
      end else begin
        m = v[k] < 0 ? -v[k] : v[k];
        q = ((m << VFB) + len / 2) / len;
        if (q > lim) q = lim;
        o[k] = v[k] < 0 ? -q[15:0] : q[15:0];
      end
    end
  endfunction

  function automatic basis_t camera_basis(logic signed [16:0] pitch, logic signed [16:0] yaw);
    longint cp, sp, cy, sy, sg;
    longint f[3], rd[3], ud[3];
    logic signed [15:0] fo[3], ro[3], uo[3];
    basis_t b;
    rotate_angle(longint'(pitch) * (64'sd1 <<< (16 - AFB)), cp, sp);
    rotate_angle(longint'(yaw) * (64'sd1 <<< (16 - AFB)), cy, sy);
    f[0] = floor_shr(cy * cp, IFB);
    f[1] = sp;
    f[2] = floor_shr(sy * cp, IFB);
    unit_vector(f, fo);
    ro = '{0, 0, 0};
    uo = '{0, 0, 0};
    b.degen = (cp < 0 ? -cp : cp) < DEGEN_LIM;
    if (!b.degen) begin
      sg = cp < 0 ? -1 : 1;
      rd[0] = -sy * sg;
      rd[1] = 0;
      rd[2] = cy * sg;
      ud[0] = -floor_shr(cy * sp, IFB) * sg;
      ud[1] = cp * sg;
      ud[2] = -floor_shr(sy * sp, IFB) * sg;
      unit_vector(rd, ro);
      unit_vector(ud, uo);
    end
    {b.fx, b.fy, b.fz} = {fo[0], fo[1], fo[2]};
    {b.rx, b.ry, b.rz} = {ro[0], ro[1], ro[2]};
    {b.ux, b.uy, b.uz} = {uo[0], uo[1], uo[2]};
    return b;
  endfunction

  task automatic send_angles(input logic signed [16:0] pitch, input logic signed [16:0] yaw,
                             input bit known, input basis_t want);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, yaw, pitch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    basis_q.push_back(known ? want : camera_basis(pitch, yaw));
  endtask

  function automatic basis_t fixed_basis(int fx, int fy, int fz, int rx, int ry, int rz,
                                         int ux, int uy, int uz, bit dg);
    basis_t b;
    b = '{fx, fy, fz, rx, ry, rz, ux, uy, uz, dg};
    return b;
  endfunction

  task automatic check_field(string name, logic signed [15:0] exp_v, logic signed [15:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    basis_t got, exp_b;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got.degen = m_tuser;
        {got.uz, got.uy, got.ux, got.rz, got.ry, got.rx, got.fz, got.fy, got.fx} = m_tdata;
        if (basis_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          exp_b = basis_q.pop_front();
          check_field("front_x", exp_b.fx, got.fx);
          check_field("front_y", exp_b.fy, got.fy);
          check_field("front_z", exp_b.fz, got.fz);
          check_field("right_x", exp_b.rx, got.rx);
          check_field("right_y", exp_b.ry, got.ry);
          check_field("right_z", exp_b.rz, got.rz);
          check_field("up_x", exp_b.ux, got.ux);
          check_field("up_y", exp_b.uy, got.uy);
          check_field("up_z", exp_b.uz, got.uz);
          check_field("degenerate", 16'(exp_b.degen), 16'(got.degen));
        end
      end
      m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      if (idle_cycles >= WATCHDOG) begin
        $display("camera_basis_from_yaw_pitch_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int pct_send[4];
    int pct_recv[4];
    logic signed [16:0] p, y;
    int wait_n;
    pct_send = '{0, 71, 0, 21};
    pct_recv = '{0, 0, 71, 21};
    rows.push_back('{17'sd0, 17'sd0, 1'b1, fixed_basis(32767, 0, 0, 0, 0, 32767, 0, 32767, 0, 0)});
    rows.push_back('{17'sd11520, 17'sd0, 1'b1, fixed_basis(0, 32767, 0, 0, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{-17'sd11520, 17'sd0, 1'b1, fixed_basis(0, -32767, 0, 0, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{17'sd0, 17'sd11520, 1'b0, '0});
    rows.push_back('{17'sd46080, 17'sd46080, 1'b0, '0});
    rows.push_back('{-17'sd46080, -17'sd46080, 1'b0, '0});
    rows.push_back('{17'sd23040, 17'sd23040, 1'b0, '0});
    rows.push_back('{-17'sd65536, 17'sd65535, 1'b0, '0});
    rows.push_back('{17'sd65535, -17'sd65536, 1'b0, '0});
    rows.push_back('{17'sd34560, -17'sd34560, 1'b0, '0});
    rows.push_back('{17'sd11519, 17'sd5760, 1'b0, '0});
    rows.push_back('{17'sd11521, -17'sd5760, 1'b0, '0});
    rows.push_back('{-17'sd34560, 17'sd100, 1'b0, '0});
    rows.push_back('{17'sd1, -17'sd1, 1'b0, '0});
    rows.push_back('{-17'sd1, 17'sd1, 1'b0, '0});
    rows.push_back('{17'sd50000, -17'sd50000, 1'b0, '0});
    rows.push_back('{17'sd43690, 17'sd21845, 1'b0, '0});
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_angles(rows[i].pitch, rows[i].yaw, rows[i].known, rows[i].want);
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = pct_send[ph % 4];
      recv_stall_pct = pct_recv[ph % 4];
      for (int n = 0; n < NUM_RANDOM / 8; n++) begin
        case ($urandom_range(3))
          0: begin
            p = 17'($urandom);
            y = 17'($urandom);
          end
          1: begin
            p = 17'($urandom_range(92160) - 46080);
            y = 17'($urandom_range(92160) - 46080);
          end
          2: begin
            p = 17'(11520 * ($urandom_range(6) - 3) + $urandom_range(6) - 3);
            y = 17'($urandom_range(92160) - 46080);
          end
          default: begin
            p = 17'(5760 * ($urandom_range(16) - 8));
            y = 17'(5760 * ($urandom_range(16) - 8) + $urandom_range(2) - 1);
          end
        endcase
        send_angles(p, y, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_n = 0;
    while (basis_q.size() != 0 && wait_n < WATCHDOG * 4) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0 && basis_q.size() == 0) begin
      $display("camera_basis_from_yaw_pitch_unit: match");
    end else begin
      $display("camera_basis_from_yaw_pitch_unit: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
